/* rtl/rv64_integer_decode_execute_macros.svh */
// Assertion macros used by the RTL of the RV64 decode/execute block (rvde_back.sv).
`ifndef RV64_INTEGER_DECODE_EXECUTE_MACROS_SVH
`define RV64_INTEGER_DECODE_EXECUTE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequence must hold in the same cycle as the antecedent.
`define RVDE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvde assertion failed");
// Consequence must hold in the cycle after the antecedent.
`define RVDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvde assertion failed");
`else
`define RVDE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RVDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rvde_pkg.sv */
// Types, codes and helper functions of the RV64 decode/execute block.
package rvde_pkg;

    localparam int XLEN     = 64;
    localparam int NUM_REGS = 32;
    localparam int RIDX_W   = 5;

    localparam logic [XLEN-1:0] SP_RESET = 64'h0000_0000_8800_0000;

    // Commands carried by a request
    localparam logic [1:0] CMD_EXEC    = 2'd0;
    localparam logic [1:0] CMD_DATA    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_LOAD       = 3'd1;
    localparam logic [2:0] ST_ILLEGAL    = 3'd2;
    localparam logic [2:0] ST_UNEXPECTED = 3'd3;
    localparam logic [2:0] ST_BUSY       = 3'd4;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_OPIMM = 7'h13;
    localparam logic [6:0] OPC_OP    = 7'h33;

    // funct7 values
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    // funct3 values of the integer groups
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Upper immediate bits selecting the shift flavour
    localparam logic [5:0] SHIFT_HI_LOGIC = 6'h00;
    localparam logic [5:0] SHIFT_HI_ARITH = 6'h10;

    // Load kinds (load funct3)
    localparam logic [2:0] LK_B   = 3'd0;
    localparam logic [2:0] LK_H   = 3'd1;
    localparam logic [2:0] LK_W   = 3'd2;
    localparam logic [2:0] LK_D   = 3'd3;
    localparam logic [2:0] LK_BU  = 3'd4;
    localparam logic [2:0] LK_HU  = 3'd5;
    localparam logic [2:0] LK_WU  = 3'd6;
    localparam logic [2:0] LK_BAD = 3'd7;

    // Classes assigned by the front end
    localparam logic [2:0] KD_OP      = 3'd0;
    localparam logic [2:0] KD_LOAD    = 3'd1;
    localparam logic [2:0] KD_DATA    = 3'd2;
    localparam logic [2:0] KD_RESTART = 3'd3;
    localparam logic [2:0] KD_ILLEGAL = 3'd4;
    localparam logic [2:0] KD_IGNORE  = 3'd5;

    // ALU operations
    localparam logic [3:0] ALU_ADD  = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd1;
    localparam logic [3:0] ALU_MUL  = 4'd2;
    localparam logic [3:0] ALU_SLL  = 4'd3;
    localparam logic [3:0] ALU_SLT  = 4'd4;
    localparam logic [3:0] ALU_SLTU = 4'd5;
    localparam logic [3:0] ALU_XOR  = 4'd6;
    localparam logic [3:0] ALU_SRL  = 4'd7;
    localparam logic [3:0] ALU_SRA  = 4'd8;
    localparam logic [3:0] ALU_OR   = 4'd9;
    localparam logic [3:0] ALU_AND  = 4'd10;

    typedef struct packed {
        logic [1:0]      command;
        logic [31:0]     instruction_word;
        logic [XLEN-1:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic              write_enable;
        logic [RIDX_W-1:0] write_index;
        logic [XLEN-1:0]   write_value;
        logic [XLEN-1:0]   load_address;
        logic [1:0]        load_size;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        op;
        logic              use_imm;
        logic [RIDX_W-1:0] rd;
        logic [RIDX_W-1:0] rs1;
        logic [RIDX_W-1:0] rs2;
        logic [2:0]        f3;
        logic [11:0]       imm;
        logic [XLEN-1:0]   load_data;
    } t_uop;

    typedef struct packed {
        logic valid;
        t_uop uop;
    } t_qhead;

    function automatic logic [XLEN-1:0] extend_load(input logic [2:0] kind,
                                                    input logic [XLEN-1:0] d);
        logic [XLEN-1:0] r;
        case (kind)
            LK_B:    r = {{56{d[7]}}, d[7:0]};
            LK_H:    r = {{48{d[15]}}, d[15:0]};
            LK_W:    r = {{32{d[31]}}, d[31:0]};
            LK_BU:   r = {56'd0, d[7:0]};
            LK_HU:   r = {48'd0, d[15:0]};
            LK_WU:   r = {32'd0, d[31:0]};
            default: r = d;
        endcase
        return r;
    endfunction

    // Register value as seen by a reader: x0 is zero, the newest write wins, an entry
    // not written since restart holds its restart value.
    function automatic logic [XLEN-1:0] reg_select(input logic [RIDX_W-1:0] idx,
                                                   input logic [XLEN-1:0] ram_val,
                                                   input logic byp_en,
                                                   input logic [RIDX_W-1:0] byp_idx,
                                                   input logic [XLEN-1:0] byp_val,
                                                   input logic written,
                                                   input logic [XLEN-1:0] sp);
        logic [XLEN-1:0] r;
        if (idx == '0) begin
            r = '0;
        end else if (byp_en && (byp_idx == idx)) begin
            r = byp_val;
        end else if (written) begin
            r = ram_val;
        end else if (idx == RIDX_W'(2)) begin
            r = sp;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

/* rtl/rvde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rvde_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rvde_front.sv */
// Front end: classifies each incoming request into a micro-operation.
module rvde_front (
    input  logic              i_in_valid,
    input  logic              i_full,
    input  rvde_pkg::t_in_item i_item,
    output logic              o_push,
    output rvde_pkg::t_uop    o_uop
);

    logic [31:0] w;
    logic [6:0]  opcode;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [5:0]  hi6;

    assign w      = i_item.instruction_word;
    assign opcode = w[6:0];
    assign f3     = w[14:12];
    assign f7     = w[31:25];
    assign hi6    = w[31:26];
    assign o_push = i_in_valid && !i_full;

    always_comb begin
        o_uop           = '0;
        o_uop.rd        = w[11:7];
        o_uop.f3        = f3;
        o_uop.rs1       = w[19:15];
        o_uop.rs2       = w[24:20];
        o_uop.imm       = w[31:20];
        o_uop.load_data = i_item.load_data;
        o_uop.op        = rvde_pkg::ALU_ADD;
        unique case (i_item.command)
            rvde_pkg::CMD_EXEC: begin
                unique case (opcode)
                    rvde_pkg::OPC_LOAD: begin
                        o_uop.kind = (f3 == rvde_pkg::LK_BAD) ? rvde_pkg::KD_ILLEGAL
                                                              : rvde_pkg::KD_LOAD;
                    end
                    rvde_pkg::OPC_OPIMM: begin
                        o_uop.kind    = rvde_pkg::KD_OP;
                        o_uop.use_imm = 1'b1;
                        unique case (f3)
                            rvde_pkg::F3_ADD:  o_uop.op = rvde_pkg::ALU_ADD;
                            rvde_pkg::F3_SLL: begin
                                o_uop.op = rvde_pkg::ALU_SLL;
                                if (hi6 != rvde_pkg::SHIFT_HI_LOGIC) begin
                                    o_uop.kind = rvde_pkg::KD_ILLEGAL;
                                end
                            end
                            rvde_pkg::F3_SLT:  o_uop.op = rvde_pkg::ALU_SLT;
                            rvde_pkg::F3_SLTU: o_uop.op = rvde_pkg::ALU_SLTU;
                            rvde_pkg::F3_XOR:  o_uop.op = rvde_pkg::ALU_XOR;
                            rvde_pkg::F3_SR: begin
                                if (hi6 == rvde_pkg::SHIFT_HI_LOGIC) begin
                                    o_uop.op = rvde_pkg::ALU_SRL;
                                end else if (hi6 == rvde_pkg::SHIFT_HI_ARITH) begin
                                    o_uop.op = rvde_pkg::ALU_SRA;
                                end else begin
                                    o_uop.kind = rvde_pkg::KD_ILLEGAL;
                                end
                            end
                            rvde_pkg::F3_OR:   o_uop.op = rvde_pkg::ALU_OR;
                            default:           o_uop.op = rvde_pkg::ALU_AND;
                        endcase
                    end
                    rvde_pkg::OPC_OP: begin
                        o_uop.kind = rvde_pkg::KD_OP;
                        if (f7 == rvde_pkg::F7_BASE) begin
                            unique case (f3)
                                rvde_pkg::F3_ADD:  o_uop.op = rvde_pkg::ALU_ADD;
                                rvde_pkg::F3_SLL:  o_uop.op = rvde_pkg::ALU_SLL;
                                rvde_pkg::F3_SLT:  o_uop.op = rvde_pkg::ALU_SLT;
                                rvde_pkg::F3_SLTU: o_uop.op = rvde_pkg::ALU_SLTU;
                                rvde_pkg::F3_XOR:  o_uop.op = rvde_pkg::ALU_XOR;
                                rvde_pkg::F3_OR:   o_uop.op = rvde_pkg::ALU_OR;
                                rvde_pkg::F3_AND:  o_uop.op = rvde_pkg::ALU_AND;
                                default:           o_uop.kind = rvde_pkg::KD_ILLEGAL;
                            endcase
                        end else if (f7 == rvde_pkg::F7_MULDIV && f3 == rvde_pkg::F3_ADD) begin
                            o_uop.op = rvde_pkg::ALU_MUL;
                        end else if (f7 == rvde_pkg::F7_ALT && f3 == rvde_pkg::F3_ADD) begin
                            o_uop.op = rvde_pkg::ALU_SUB;
                        end else if (f7 == rvde_pkg::F7_ALT && f3 == rvde_pkg::F3_SR) begin
                            o_uop.op = rvde_pkg::ALU_SRA;
                        end else begin
                            o_uop.kind = rvde_pkg::KD_ILLEGAL;
                        end
                    end
                    default: o_uop.kind = rvde_pkg::KD_ILLEGAL;
                endcase
            end
            rvde_pkg::CMD_DATA:    o_uop.kind = rvde_pkg::KD_DATA;
            rvde_pkg::CMD_RESTART: o_uop.kind = rvde_pkg::KD_RESTART;
            default:               o_uop.kind = rvde_pkg::KD_IGNORE;
        endcase
    end

endmodule

/* rtl/rvde_queue.sv */
// Short FIFO of decoded micro-operations between the front and back ends.
module rvde_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rvde_pkg::t_uop   i_uop,
    input  logic             i_pop,
    output logic             o_full,
    output rvde_pkg::t_qhead o_head
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rvde_pkg::t_uop r_mem [DEPTH];
    logic [IW-1:0]  r_head;
    logic [IW-1:0]  r_tail;
    logic [CW-1:0]  r_count;
    logic           do_pop;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
    endfunction

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.uop   = r_mem[r_head];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= wrap_inc(r_tail);
            end
            if (do_pop) begin
                r_head <= wrap_inc(r_head);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_uop;
        end
    end

endmodule

/* rtl/rvde_back.sv */
// Back end: register read, execute, architectural state and the result register.
`include "rv64_integer_decode_execute_macros.svh"
module rvde_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_init_sp,
    input  rvde_pkg::t_qhead    i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rvde_pkg::t_out_item o_out
);

    logic                r_e1_valid;
    logic                r_e2_valid;
    rvde_pkg::t_uop      r_e1;
    rvde_pkg::t_uop      r_e2;
    logic [31:0]         r_vld;
    logic                r_byp_en;
    logic [4:0]          r_byp_idx;
    logic [63:0]         r_byp_val;
    logic [63:0]         r_sp;
    logic                r_pend;
    logic [4:0]          r_pend_rd;
    logic [2:0]          r_pend_kind;
    logic                r_mul_ph;
    logic [63:0]         r_mul_ll;
    logic [31:0]         r_mul_lh;
    logic [31:0]         r_mul_hl;
    logic                r_out_valid;
    rvde_pkg::t_out_item r_out;

    logic [4:0]          raddr_a;
    logic [4:0]          raddr_b;
    logic [63:0]         ram_a;
    logic [63:0]         ram_b;
    logic [63:0]         opa;
    logic [63:0]         opb;
    logic [63:0]         imm64;
    logic [63:0]         alu;
    logic [63:0]         mul_res;
    logic                mul_wait;
    logic                out_free;
    logic                e2_fire;
    logic                e2_take;
    logic                e1_take;
    rvde_pkg::t_out_item res;
    logic                wr;
    logic                set_pend;
    logic                clr_pend;
    logic                restart;
    logic                ram_we;
    logic [4:0]          ram_waddr;

    assign out_free = !r_out_valid || !i_out_stall;
    assign mul_wait = r_e2_valid && (r_e2.kind == rvde_pkg::KD_OP)
                      && (r_e2.op == rvde_pkg::ALU_MUL) && !r_pend && !r_mul_ph;
    assign e2_fire  = r_e2_valid && !mul_wait && out_free;
    assign e2_take  = !r_e2_valid || e2_fire;
    assign e1_take  = !r_e1_valid || e2_take;
    assign o_pop    = e1_take && i_head.valid;

    // Read data always belongs to the item that sits in the execute stage next cycle.
    assign raddr_a = e2_take ? r_e1.rs1 : r_e2.rs1;
    assign raddr_b = e2_take ? r_e1.rs2 : r_e2.rs2;

    assign ram_we    = e2_fire && wr;
    assign ram_waddr = res.write_index;

    rvde_ram #(.WIDTH(64), .DEPTH(rvde_pkg::NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (res.write_value),
        .i_raddr (raddr_a),
        .o_rdata (ram_a)
    );

    rvde_ram #(.WIDTH(64), .DEPTH(rvde_pkg::NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (res.write_value),
        .i_raddr (raddr_b),
        .o_rdata (ram_b)
    );

    assign imm64 = {{52{r_e2.imm[11]}}, r_e2.imm};
    assign opa   = rvde_pkg::reg_select(r_e2.rs1, ram_a, r_byp_en, r_byp_idx, r_byp_val,
                                        r_vld[r_e2.rs1], r_sp);
    assign opb   = r_e2.use_imm ? imm64
                 : rvde_pkg::reg_select(r_e2.rs2, ram_b, r_byp_en, r_byp_idx, r_byp_val,
                                        r_vld[r_e2.rs2], r_sp);

    assign mul_res = r_mul_ll + {r_mul_lh + r_mul_hl, 32'd0};

    always_comb begin
        unique case (r_e2.op)
            rvde_pkg::ALU_ADD:  alu = opa + opb;
            rvde_pkg::ALU_SUB:  alu = opa - opb;
            rvde_pkg::ALU_SLL:  alu = opa << opb[5:0];
            rvde_pkg::ALU_SLT:  alu = {63'd0, $signed(opa) < $signed(opb)};
            rvde_pkg::ALU_SLTU: alu = {63'd0, opa < opb};
            rvde_pkg::ALU_XOR:  alu = opa ^ opb;
            rvde_pkg::ALU_SRL:  alu = opa >> opb[5:0];
            rvde_pkg::ALU_SRA:  alu = 64'($signed(opa) >>> opb[5:0]);
            rvde_pkg::ALU_OR:   alu = opa | opb;
            rvde_pkg::ALU_AND:  alu = opa & opb;
            default:            alu = mul_res;
        endcase
    end

    always_comb begin
        res      = '0;
        wr       = 1'b0;
        set_pend = 1'b0;
        clr_pend = 1'b0;
        restart  = 1'b0;
        unique case (r_e2.kind)
            rvde_pkg::KD_RESTART: begin
                res.status = rvde_pkg::ST_DONE;
                restart    = 1'b1;
            end
            rvde_pkg::KD_DATA: begin
                if (!r_pend) begin
                    res.status = rvde_pkg::ST_UNEXPECTED;
                end else begin
                    res.status       = rvde_pkg::ST_DONE;
                    res.write_index  = r_pend_rd;
                    res.write_value  = rvde_pkg::extend_load(r_pend_kind, r_e2.load_data);
                    res.write_enable = (r_pend_rd != '0);
                    wr               = (r_pend_rd != '0);
                    clr_pend         = 1'b1;
                end
            end
            rvde_pkg::KD_LOAD: begin
                if (r_pend) begin
                    res.status = rvde_pkg::ST_BUSY;
                end else begin
                    res.status       = rvde_pkg::ST_LOAD;
                    res.load_address = opa + imm64;
                    res.load_size    = r_e2.f3[1:0];
                    set_pend         = 1'b1;
                end
            end
            rvde_pkg::KD_ILLEGAL: begin
                res.status = r_pend ? rvde_pkg::ST_BUSY : rvde_pkg::ST_ILLEGAL;
            end
            rvde_pkg::KD_OP: begin
                if (r_pend) begin
                    res.status = rvde_pkg::ST_BUSY;
                end else begin
                    res.status       = rvde_pkg::ST_DONE;
                    res.write_index  = r_e2.rd;
                    res.write_value  = alu;
                    res.write_enable = (r_e2.rd != '0);
                    wr               = (r_e2.rd != '0);
                end
            end
            default: res.status = rvde_pkg::ST_BUSY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid  <= 1'b0;
            r_e2_valid  <= 1'b0;
            r_vld       <= '0;
            r_byp_en    <= 1'b0;
            r_sp        <= rvde_pkg::SP_RESET;
            r_pend      <= 1'b0;
            r_pend_rd   <= '0;
            r_pend_kind <= '0;
            r_mul_ph    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (e1_take) begin
                r_e1_valid <= i_head.valid;
            end
            if (e2_take) begin
                r_e2_valid <= r_e1_valid;
            end
            if (mul_wait) begin
                r_mul_ph <= 1'b1;
            end else if (e2_fire) begin
                r_mul_ph <= 1'b0;
            end
            if (e2_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
                r_byp_en         <= 1'b1;
            end
            if (e2_fire && set_pend) begin
                r_pend      <= 1'b1;
                r_pend_rd   <= r_e2.rd;
                r_pend_kind <= r_e2.f3;
            end
            if (e2_fire && clr_pend) begin
                r_pend <= 1'b0;
            end
            if (e2_fire && restart) begin
                r_vld       <= '0;
                r_byp_en    <= 1'b0;
                r_pend      <= 1'b0;
                r_pend_rd   <= '0;
                r_pend_kind <= '0;
                r_sp        <= i_init_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1_take) begin
            r_e1 <= i_head.uop;
        end
        if (e2_take) begin
            r_e2 <= r_e1;
        end
        if (mul_wait) begin
            r_mul_ll <= opa[31:0] * opb[31:0];
            r_mul_lh <= 32'(opa[31:0] * opb[63:32]);
            r_mul_hl <= 32'(opa[63:32] * opb[31:0]);
        end
        if (ram_we) begin
            r_byp_idx <= ram_waddr;
            r_byp_val <= res.write_value;
        end
        if (e2_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `RVDE_ASSERT_SAME(a_no_x0_write, i_clk, i_rst_n, ram_we, ram_waddr != '0)
    `RVDE_ASSERT_SAME(a_mul_phase_owner, i_clk, i_rst_n, r_mul_ph, r_e2_valid && (r_e2.op == rvde_pkg::ALU_MUL))
    `RVDE_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, e2_fire && (r_e2.kind == rvde_pkg::KD_RESTART), (r_vld == '0) && !r_pend && !r_byp_en)
    `RVDE_ASSERT_NEXT(a_data_ends_load, i_clk, i_rst_n, e2_fire && (r_e2.kind == rvde_pkg::KD_DATA) && r_pend, !r_pend)

endmodule

/* rtl/rv64_integer_decode_execute.sv */
// Top level of the RV64 integer decode/execute block.
// This block executes a subset of RV64I plus the low half of MUL. Each request is an
// instruction, returned load data or a restart, and every request yields exactly one
// result, in order. A front end decodes and classifies each request and places it in a
// short queue of QUEUE_DEPTH entries; the back end reads the register file (two
// registered-read RAM copies, one per source operand), executes, updates the register
// file and the load state, and holds the result in an output register, so the block
// keeps taking requests while a result waits to be taken, until the queue fills. One
// request per cycle is sustained while the output does not stall; a MUL stays in the
// execute stage for partial products, then the final sum, holding back later requests.
// An accepted request passes from the queue through register read and execute into the
// output register. A load answers with status 1 and the address; the next data request
// completes it, and any instruction in between is refused with status 4. Restart clears
// all registers at once through per-register valid bits and loads x2 with the initial
// stack pointer held in the configuration register at byte address 0.
module rv64_integer_decode_execute #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rvde_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rvde_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    logic [63:0]      r_init_sp;
    logic             cfg_wr;
    logic             q_full;
    logic             push;
    logic             pop;
    rvde_pkg::t_uop   uop;
    rvde_pkg::t_qhead head;

    // The stack pointer register occupies the 64-bit word at address 0; bits [2:0]
    // are the byte offset and bit 3 selects the register slot.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata = (paddr[3] == 1'b0) ? r_init_sp : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_sp <= rvde_pkg::SP_RESET;
        end else if (cfg_wr) begin
            r_init_sp <= pwdata;
        end
    end

    // Requests are refused only when the queue is full; this never looks at i_in_valid.
    assign o_in_stall = q_full;

    rvde_front u_front (
        .i_in_valid (i_in_valid),
        .i_full     (q_full),
        .i_item     (i_in),
        .o_push     (push),
        .o_uop      (uop)
    );

    rvde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (uop),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    rvde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_sp   (r_init_sp),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* tb/rvde_checker.sv */
// Result checker for the RV64 decode/execute block: mirrors its behaviour and compares results.
`timescale 1ns / 1ps
module rvde_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  rvde_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  rvde_pkg::t_out_item i_out,
    input  logic                i_cfg_we,
    input  logic [63:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import rvde_pkg::*;

    logic [63:0] gpr [32];
    logic [63:0] stack_init;
    logic        ld_wait;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;
    t_out_item   expected_results [$];

    function automatic logic [63:0] sar64(input logic [63:0] v, input logic [5:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] sized_load(input logic [2:0] k, input logic [63:0] d);
        case (k)
            LK_B:    return {{56{d[7]}}, d[7:0]};
            LK_H:    return {{48{d[15]}}, d[15:0]};
            LK_W:    return {{32{d[31]}}, d[31:0]};
            LK_BU:   return {56'd0, d[7:0]};
            LK_HU:   return {48'd0, d[15:0]};
            LK_WU:   return {32'd0, d[31:0]};
            default: return d;
        endcase
    endfunction

    task automatic clear_regs();
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        gpr[2] = stack_init;
        ld_wait = 1'b0;
        ld_dest = '0;
        ld_kind = '0;
    endtask

    task automatic execute_request(input t_in_item it);
        t_out_item   o;
        logic [31:0] w;
        logic [6:0]  opc, f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [63:0] imm, a, b, r;
        logic [5:0]  hi6;
        logic        ok;
        o = '0;
        r = '0;
        ok = 1'b1;
        w = it.instruction_word;
        opc = w[6:0];
        rd = w[11:7];
        f3 = w[14:12];
        rs1 = w[19:15];
        rs2 = w[24:20];
        f7 = w[31:25];
        imm = {{52{w[31]}}, w[31:20]};
        hi6 = imm[11:6];
        a = gpr[rs1];
        b = gpr[rs2];
        if (it.command == CMD_RESTART) begin
            clear_regs();
            o.status = ST_DONE;
        end else if (it.command == CMD_DATA) begin
            if (!ld_wait) begin
                o.status = ST_UNEXPECTED;
            end else begin
                r = sized_load(ld_kind, it.load_data);
                if (ld_dest != 0) gpr[ld_dest] = r;
                ld_wait = 1'b0;
                o.status = ST_DONE;
                o.write_enable = ld_dest != 0;
                o.write_index = ld_dest;
                o.write_value = r;
            end
        end else if (it.command != CMD_EXEC || ld_wait) begin
            o.status = ST_BUSY;
        end else if (opc == OPC_LOAD) begin
            if (f3 == LK_BAD) begin
                o.status = ST_ILLEGAL;
            end else begin
                ld_wait = 1'b1;
                ld_dest = rd;
                ld_kind = f3;
                o.status = ST_LOAD;
                o.load_address = a + imm;
                o.load_size = f3[1:0];
            end
        end else begin
            if (opc == OPC_OPIMM) begin
                case (f3)
                    F3_ADD:  r = a + imm;
                    F3_SLL: begin
                        ok = hi6 == SHIFT_HI_LOGIC;
                        r = a << imm[5:0];
                    end
                    F3_SLT:  r = {63'd0, $signed(a) < $signed(imm)};
                    F3_SLTU: r = {63'd0, a < imm};
                    F3_XOR:  r = a ^ imm;
                    F3_SR: begin
                        if (hi6 == SHIFT_HI_LOGIC) r = a >> imm[5:0];
                        else if (hi6 == SHIFT_HI_ARITH) r = sar64(a, imm[5:0]);
                        else ok = 1'b0;
                    end
                    F3_OR:   r = a | imm;
                    default: r = a & imm;
                endcase
            end else if (opc == OPC_OP) begin
                if (f3 == F3_ADD && f7 == F7_BASE) r = a + b;
                else if (f3 == F3_ADD && f7 == F7_MULDIV) r = a * b;
                else if (f3 == F3_ADD && f7 == F7_ALT) r = a - b;
                else if (f3 == F3_SLL && f7 == F7_BASE) r = a << b[5:0];
                else if (f3 == F3_SLT && f7 == F7_BASE) r = {63'd0, $signed(a) < $signed(b)};
                else if (f3 == F3_SLTU && f7 == F7_BASE) r = {63'd0, a < b};
                else if (f3 == F3_XOR && f7 == F7_BASE) r = a ^ b;
                else if (f3 == F3_SR && f7 == F7_ALT) r = sar64(a, b[5:0]);
                else if (f3 == F3_OR && f7 == F7_BASE) r = a | b;
                else if (f3 == F3_AND && f7 == F7_BASE) r = a & b;
                else ok = 1'b0;
            end else begin
                ok = 1'b0;
            end
            if (!ok) begin
                o.status = ST_ILLEGAL;
            end else begin
                if (rd != 0) gpr[rd] = r;
                o.status = ST_DONE;
                o.write_enable = rd != 0;
                o.write_index = rd;
                o.write_value = r;
            end
        end
        expected_results.push_back(o);
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item e;
        if (expected_results.size() == 0) begin
            $error("result with no request outstanding: %h", got);
            o_fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            o_fail_count++;
        end
        if (got.write_enable !== e.write_enable) begin
            $error("write_enable: expected %0d, got %0d", e.write_enable, got.write_enable);
            o_fail_count++;
        end
        if (got.write_index !== e.write_index) begin
            $error("write_index: expected %0d, got %0d", e.write_index, got.write_index);
            o_fail_count++;
        end
        if (got.write_value !== e.write_value) begin
            $error("write_value: expected %h, got %h", e.write_value, got.write_value);
            o_fail_count++;
        end
        if (got.load_address !== e.load_address) begin
            $error("load_address: expected %h, got %h", e.load_address, got.load_address);
            o_fail_count++;
        end
        if (got.load_size !== e.load_size) begin
            $error("load_size: expected %0d, got %0d", e.load_size, got.load_size);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        stack_init = SP_RESET;
        clear_regs();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_init = SP_RESET;
            clear_regs();
        end else begin
            if (i_cfg_we) stack_init = i_cfg_data;
            if (i_out_valid && !i_out_stall) compare_result(i_out);
            if (i_in_valid && !i_in_stall) execute_request(i_in);
        end
        o_pending = expected_results.size();
    end
endmodule

/* tb/tb.sv */
// Top-level testbench of the RV64 decode/execute block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
    import rvde_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          stall_on = 1'b1;

    localparam int WATCHDOG = 2000;
    localparam logic [3:0] ADDR_STACK_INIT = 4'd0;

    always #6 i_clk = ~i_clk;

    rv64_integer_decode_execute i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The checker sees a configuration write at the same edge as the block does.
    rvde_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .i_cfg_we(psel && penable && pwrite && pready && paddr == ADDR_STACK_INIT),
        .i_cfg_data(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The watchdog counts cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // The receiver stalls at random, with stretches in which it never stalls.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_on <= ~stall_on;
        out_stall <= stall_on && (gap_len() != 0);
    end

    // Present one request and hold it until the block takes it. Valid stays high after
    // acceptance so that a following request can go out back to back; a gap or a
    // drain drops it.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] w,
                                input logic [63:0] d);
        int g;
        g = gap_len();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_item.command <= cmd;
        in_item.instruction_word <= w;
        in_item.load_data <= d;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_stack_init(input logic [63:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_STACK_INIT;
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3, input logic [4:0] rd,
                                           input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly well-formed instructions, with random fields and some noise.
    function automatic logic [31:0] random_instruction();
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [6:0]  f7;
        int          pick;
        f3 = 3'($urandom_range(0, 7));
        imm = 12'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if (f3 == F3_SLL) imm[11:6] = SHIFT_HI_LOGIC;
            if (f3 == F3_SR) imm[11:6] = $urandom_range(0, 1) ? SHIFT_HI_ARITH
                                                               : SHIFT_HI_LOGIC;
            if ($urandom_range(0, 9) == 0) imm = 12'($urandom());
            return i_type(imm, 5'($urandom()), f3, 5'($urandom()), OPC_OPIMM);
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: f7 = F7_ALT;
                1: f7 = F7_MULDIV;
                2: f7 = 7'($urandom());
                default: f7 = F7_BASE;
            endcase
            return r_type(f7, 5'($urandom()), 5'($urandom()), f3, 5'($urandom()), OPC_OP);
        end else if (pick < 95) begin
            return i_type(imm, 5'($urandom()), f3, 5'($urandom()), OPC_LOAD);
        end
        return $urandom();
    endfunction

    initial begin
        logic [63:0] sp_values [4];
        sp_values = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd0};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, a selection of operations and the special cases.
        send_request(CMD_EXEC, i_type(12'h7FF, 5'd2, F3_ADD, 5'd1, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'h800, 5'd1, F3_ADD, 5'd3, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'h03F, 5'd3, F3_SLL, 5'd4, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'h43F, 5'd3, F3_SR, 5'd5, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'h001, 5'd3, F3_SR, 5'd6, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'h041, 5'd3, F3_SR, 5'd6, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'hFFF, 5'd3, F3_SLT, 5'd7, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'hFFF, 5'd3, F3_SLTU, 5'd8, OPC_OPIMM), '0);
        send_request(CMD_EXEC, i_type(12'hFFF, 5'd2, F3_XOR, 5'd0, OPC_OPIMM), '0);
        send_request(CMD_EXEC, r_type(F7_MULDIV, 5'd3, 5'd1, F3_ADD, 5'd9, OPC_OP), '0);
        send_request(CMD_EXEC, r_type(F7_ALT, 5'd3, 5'd1, F3_ADD, 5'd10, OPC_OP), '0);
        send_request(CMD_EXEC, r_type(F7_ALT, 5'd1, 5'd3, F3_SR, 5'd11, OPC_OP), '0);
        send_request(CMD_EXEC, r_type(F7_BASE, 5'd1, 5'd3, F3_SR, 5'd11, OPC_OP), '0);
        send_request(CMD_EXEC, r_type(F7_BASE, 5'd3, 5'd1, F3_SLT, 5'd12, OPC_OP), '0);
        send_request(CMD_DATA, '0, '1);
        send_request(CMD_EXEC, i_type(12'hFFF, 5'd3, LK_B, 5'd13, OPC_LOAD), '0);
        send_request(CMD_EXEC, i_type(12'h0, 5'd3, F3_ADD, 5'd13, OPC_OPIMM), '0);
        send_request(CMD_NONE, '0, '0);
        send_request(CMD_DATA, '0, 64'hFFFF_FFFF_FFFF_FF80);
        send_request(CMD_EXEC, i_type(12'h0, 5'd2, LK_BAD, 5'd14, OPC_LOAD), '0);
        send_request(CMD_EXEC, i_type(12'h7FF, 5'd2, LK_D, 5'd0, OPC_LOAD), '0);
        send_request(CMD_DATA, '0, 64'h8000_0000_0000_0001);
        send_request(CMD_EXEC, 32'hFFFF_FFFF, '0);
        send_request(CMD_RESTART, '0, '0);

        // Random phases, each under its own stack pointer setting.
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_stack_init(phase == 3 ? rand64() : sp_values[phase]);
            send_request(CMD_RESTART, '0, '0);
            for (int n = 0; n < 300; n++) begin
                int k;
                k = $urandom_range(0, 99);
                if (k < 80) send_request(CMD_EXEC, random_instruction(), '0);
                else if (k < 94) send_request(CMD_DATA, '0, rand64());
                else if (k < 97) send_request(CMD_RESTART, $urandom(), rand64());
                else send_request(CMD_NONE, $urandom(), rand64());
                if (n == 150 && phase == 1) wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

/* rv64_integer_decode_execute.f */
+incdir+rtl
rtl/rvde_pkg.sv
rtl/rvde_ram.sv
rtl/rvde_front.sv
rtl/rvde_queue.sv
rtl/rvde_back.sv
rtl/rv64_integer_decode_execute.sv
tb/rvde_checker.sv
tb/tb.sv
